/* rtl/dnsar_pkg.sv */
// ----------------------------------------------------------------------------
// dnsar_pkg
// Shared types and constants for the DNS A-query responder.
// ----------------------------------------------------------------------------
package dnsar_pkg;

	localparam int BUFFER_BYTES = 256;
	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = AW + 1;

	localparam logic [7:0] QR_BIT      = 8'h80;
	localparam logic [7:0] OPCODE_BITS = 8'h78;
	localparam logic [7:0] AA_BIT      = 8'h04;
	localparam logic [7:0] RCODE_NOTIMP = 8'h04;
	localparam logic [7:0] PTR_HI      = 8'hC0;
	localparam logic [7:0] MAX_LABEL   = 8'd63;
	localparam logic [7:0] TTL_SECONDS = 8'd60;
	localparam int         HDR_LEN     = 12;

	// controller -> datapath
	typedef struct packed {
		logic          rd_en;     // issue a store read
		logic [CW-1:0] rd_addr;
		logic          clr_word;  // start a new output word
		logic          put_byte;  // place byte into word
		logic [7:0]    put_val;
		logic          use_rd;    // byte comes from read data
	} dnsar_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [7:0] rd_data;
	} dnsar_sts_t;

endpackage

/* rtl/dnsar_if.sv */
// ----------------------------------------------------------------------------
// dnsar_in_if / dnsar_out_if
// Valid/ready channels for query bytes and reply words.
// ----------------------------------------------------------------------------
interface dnsar_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface dnsar_out_if;
	logic        valid;
	logic        ready;
	logic [63:0] reply_word;
	logic [3:0]  valid_bytes;
	logic        last_word;
	modport source (output valid, reply_word, valid_bytes, last_word, input ready);
	modport sink   (input valid, reply_word, valid_bytes, last_word, output ready);
endinterface

/* rtl/dnsar_datapath.sv */
// ----------------------------------------------------------------------------
// dnsar_datapath
// Packet store, store read port and reply word assembly.
// ----------------------------------------------------------------------------
module dnsar_datapath (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [dnsar_pkg::AW-1:0]  wr_addr,
	input  logic [7:0]                wr_data,
	input  dnsar_pkg::dnsar_cmd_t     cmd,
	output dnsar_pkg::dnsar_sts_t     sts,
	output logic [63:0]               word
);
	import dnsar_pkg::*;

	logic [7:0]  mem [BUFFER_BYTES];
	logic [7:0]  rd_q;
	logic [63:0] word_q;
	logic [7:0]  byte_v;

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.rd_en) rd_q <= mem[cmd.rd_addr[AW-1:0]];
	end

	assign byte_v = cmd.use_rd ? rd_q : cmd.put_val;

	always_ff @(posedge clk) begin
		if (cmd.clr_word) word_q <= '0;
		else if (cmd.put_byte) word_q <= {word_q[55:0], byte_v};
	end

	assign sts.rd_data = rd_q;
	assign word = word_q;
endmodule

/* rtl/dnsar_ctrl.sv */
// ----------------------------------------------------------------------------
// dnsar_ctrl
// Sequencer: receive, header check, label walk, reply emission.
// ----------------------------------------------------------------------------
module dnsar_ctrl (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [31:0]               portal_address,
	dnsar_in_if.sink                  in_ch,
	dnsar_out_if.source               out_ch,
	output logic                      wr_en,
	output logic [dnsar_pkg::AW-1:0]  wr_addr,
	output dnsar_pkg::dnsar_cmd_t     cmd,
	input  dnsar_pkg::dnsar_sts_t     sts,
	input  logic [63:0]               word
);
	import dnsar_pkg::*;

	typedef enum logic [3:0] {
		S_RX, S_RD, S_CHK, S_WALK, S_QT, S_EMIT, S_PUT, S_OUT
	} state_t;

	state_t      state_q;
	logic [CW-1:0] cnt_q;    // stored bytes
	logic [CW-1:0] pos_q;    // read position / label walk
	logic [CW-1:0] rlen_q;   // echoed length
	logic [CW:0]   opos_q;   // output byte index
	logic [CW:0]   total_q;
	logic [3:0]    hidx_q;   // header check step
	logic [3:0]    wcnt_q;   // bytes in current word
	logic [7:0]    qt_q;     // previous type/class byte
	logic [1:0]    qi_q;
	logic          ain_q;
	logic          rd_pend_q;
	logic [CW:0]   qend;
	logic [CW-1:0] ansi;
	logic [7:0]    ans_b;
	logic          take;

	assign take = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (state_q == S_RX);
	assign wr_en = take && (cnt_q < CW'(BUFFER_BYTES));
	assign wr_addr = cnt_q[AW-1:0];
	assign qend = {1'b0, pos_q} + (CW+1)'(4);
	assign ansi = CW'(opos_q) - rlen_q;

	always_comb begin
		unique case (ansi[3:0])
			4'd0:  ans_b = PTR_HI;
			4'd1:  ans_b = 8'(HDR_LEN);
			4'd3:  ans_b = 8'd1;
			4'd5:  ans_b = 8'd1;
			4'd9:  ans_b = TTL_SECONDS;
			4'd11: ans_b = 8'd4;
			4'd12: ans_b = portal_address[31:24];
			4'd13: ans_b = portal_address[23:16];
			4'd14: ans_b = portal_address[15:8];
			4'd15: ans_b = portal_address[7:0];
			default: ans_b = 8'd0;
		endcase
	end

	// datapath commands: store reads at pos_q, and the byte source for reply position opos_q
	always_comb begin
		cmd = '0;
		cmd.rd_addr = CW'(opos_q);
		unique case (state_q)
			S_RD: begin
				cmd.rd_en = 1'b1;
				cmd.rd_addr = pos_q;
			end
			S_QT: begin
				// type/class fetch: read at pos_q when no read is pending
				cmd.rd_en = !rd_pend_q;
				cmd.rd_addr = pos_q;
			end
			S_EMIT: begin
				cmd.rd_en = 1'b1;
				if (wcnt_q == 4'd0) cmd.clr_word = 1'b1;
			end
			S_PUT: begin
				cmd.put_byte = 1'b1;
				if (opos_q >= (CW+1)'(rlen_q)) cmd.put_val = ans_b;
				else if (opos_q == (CW+1)'(2)) cmd.put_val = QR_BIT | AA_BIT;
				else if (opos_q == (CW+1)'(3)) cmd.put_val = ain_q ? 8'd0 : RCODE_NOTIMP;
				else if (opos_q == (CW+1)'(7)) cmd.put_val = {7'd0, ain_q};
				else if (opos_q >= (CW+1)'(6) && opos_q < (CW+1)'(12)) cmd.put_val = 8'd0;
				else cmd.use_rd = 1'b1;
			end
			S_OUT: begin
				cmd.put_byte = !out_ch.valid && (wcnt_q != 4'd8);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_RX;
			cnt_q <= '0;
			pos_q <= '0;
			rlen_q <= '0;
			opos_q <= '0;
			total_q <= '0;
			hidx_q <= '0;
			wcnt_q <= '0;
			qt_q <= '0;
			qi_q <= '0;
			ain_q <= 1'b0;
			rd_pend_q <= 1'b0;
			out_ch.valid <= 1'b0;
			out_ch.valid_bytes <= '0;
			out_ch.last_word <= 1'b0;
		end else begin
			unique case (state_q)
				S_RX: if (take) begin
					if (cnt_q < CW'(BUFFER_BYTES)) cnt_q <= cnt_q + CW'(1);
					if (in_ch.last_byte) begin
						hidx_q <= 4'd2;
						pos_q <= CW'(2);
						state_q <= S_RD;
					end
				end
				S_RD: state_q <= S_CHK;
				S_CHK: begin
					// a dropped packet clears the count and reopens input
					priority if (hidx_q == 4'd2) begin
						if (cnt_q < CW'(HDR_LEN + 5) ||
								(sts.rd_data & (QR_BIT | OPCODE_BITS)) != 8'd0) begin
							cnt_q <= '0;
							state_q <= S_RX;
						end else begin
							hidx_q <= 4'd4;
							pos_q <= CW'(4);
							state_q <= S_RD;
						end
					end else if (hidx_q == 4'd4) begin
						if (sts.rd_data != 8'd0) begin
							cnt_q <= '0;
							state_q <= S_RX;
						end else begin
							hidx_q <= 4'd5;
							pos_q <= CW'(5);
							state_q <= S_RD;
						end
					end else if (hidx_q == 4'd5) begin
						if (sts.rd_data != 8'd1) begin
							cnt_q <= '0;
							state_q <= S_RX;
						end else begin
							hidx_q <= 4'd6;
							pos_q <= CW'(HDR_LEN);
							state_q <= S_RD;
						end
					end else begin
						state_q <= S_WALK;
					end
				end
				S_WALK: begin
					// sts holds label at pos_q
					if (sts.rd_data == 8'd0) begin
						if (qend + (CW+1)'(1) > (CW+1)'(cnt_q)) begin
							cnt_q <= '0;
							state_q <= S_RX;
						end else begin
							pos_q <= pos_q + CW'(1);
							rlen_q <= CW'(qend + (CW+1)'(1));
							qi_q <= 2'd0;
							state_q <= S_QT;
							rd_pend_q <= 1'b0;
						end
					end else if (sts.rd_data > MAX_LABEL) begin
						cnt_q <= '0;
						state_q <= S_RX;
					end else if ({1'b0, pos_q} + (CW+1)'(sts.rd_data) + (CW+1)'(1)
						>= (CW+1)'(cnt_q)) begin
						cnt_q <= '0;
						state_q <= S_RX;
					end else begin
						pos_q <= pos_q + CW'(sts.rd_data) + CW'(1);
						state_q <= S_RD;
					end
				end
				S_QT: begin
					// read four type/class bytes, alternating between issuing a read and capturing its data
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
					end else begin
						rd_pend_q <= 1'b0;
						qt_q <= sts.rd_data;
						pos_q <= pos_q + CW'(1);
						qi_q <= qi_q + 2'd1;
						if (qi_q == 2'd1) ain_q <= ({qt_q, sts.rd_data} == 16'd1);
						if (qi_q == 2'd3) begin
							ain_q <= ain_q && ({qt_q, sts.rd_data} == 16'd1);
							total_q <= (CW+1)'(rlen_q) +
								(((ain_q && {qt_q, sts.rd_data} == 16'd1))
								? (CW+1)'(16) : (CW+1)'(0));
							opos_q <= '0;
							wcnt_q <= '0;
							state_q <= S_EMIT;
						end
					end
				end
				S_EMIT: state_q <= S_PUT;
				S_PUT: begin
					opos_q <= opos_q + (CW+1)'(1);
					wcnt_q <= wcnt_q + 4'd1;
					if (wcnt_q == 4'd7 || opos_q + (CW+1)'(1) == total_q) begin
						out_ch.valid_bytes <= wcnt_q + 4'd1;
						out_ch.last_word <= (opos_q + (CW+1)'(1) == total_q);
						state_q <= S_OUT;
					end else state_q <= S_EMIT;
				end
				S_OUT: begin
					if (wcnt_q != 4'd8) wcnt_q <= wcnt_q + 4'd1;
					else if (!out_ch.valid) out_ch.valid <= 1'b1;
					else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						wcnt_q <= '0;
						if (out_ch.last_word) begin
							cnt_q <= '0;
							state_q <= S_RX;
						end else state_q <= S_EMIT;
					end
				end
				default: state_q <= S_RX;
			endcase
		end
	end

	assign out_ch.reply_word = word;

`ifndef SYNTH
	a_no_rx_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("input open during output");
	a_vb_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.valid_bytes != 4'd0 && out_ch.valid_bytes <= 4'd8))
		else $error("bad valid_bytes");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(BUFFER_BYTES)) else $error("count overflow");
`endif
endmodule

/* rtl/dns_a_query_responder_unit.sv */
// After the last byte, the header fields are checked, the name labels walked
// and the type/class bytes fetched before the first reply word goes valid.
// Input takes one query byte per cycle while it is open; each reply byte is
// a store read, then a shift, and a full word then raises valid and hands off.
// Input is closed while a packet is checked and its reply is sent.
// arst_n clears control state and portal_address; the store is not cleared.
// ----------------------------------------------------------------------------
// dns_a_query_responder_unit
// Top level: address register, controller and datapath.
// ----------------------------------------------------------------------------
module dns_a_query_responder_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	dnsar_in_if.sink    in_ch,
	dnsar_out_if.source out_ch
);
	import dnsar_pkg::*;

	logic [31:0] addr_q;   // portal address
	logic        wr_en;
	logic [AW-1:0] wr_addr;
	dnsar_cmd_t  cmd;
	dnsar_sts_t  sts;
	logic [63:0] word;
	dnsar_cmd_t  cmd_m;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) addr_q <= '0;
		else if (cfg_we) addr_q <= cfg_wdata;
	end

	// type/class fetch reads through pos_q; emission reads at opos
	always_comb begin
		cmd_m = cmd;
	end

	dnsar_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .portal_address(addr_q),
		.in_ch(in_ch), .out_ch(out_ch), .wr_en(wr_en), .wr_addr(wr_addr),
		.cmd(cmd), .sts(sts), .word(word)
	);

	dnsar_datapath u_dp (
		.clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(in_ch.data_byte),
		.cmd(cmd_m), .sts(sts), .word(word)
	);
endmodule
